### hdl/lirs_pkg.sv
// Shared types and constants for the linear interpolation resampler.
// Used by linear_interp_resampler_to_44100; depends on nothing.
package lirs_pkg;

	// Output rate, and the bounds that the source rate is clamped into.
	localparam logic [17:0] OUT_RATE = 18'd44100;
	localparam logic [17:0] RATE_MIN = 18'd8000;
	localparam logic [17:0] RATE_MAX = 18'd192000;

	// Most outputs that one segment may produce.
	localparam logic [2:0] SEG_CAP = 3'd6;

	// Reset values of the configuration registers.
	localparam logic [17:0] RATE_RESET = 18'd44100;
	localparam logic [1:0] CHAN_RESET = 2'd2;
	localparam logic [1:0] CHAN_MONO = 2'd1;

	// Configuration register indexes.
	localparam logic REG_SOURCE_RATE = 1'b0;
	localparam logic REG_CHANNEL_COUNT = 1'b1;

	// Division by OUT_RATE as a multiply by a rounded-up reciprocal.
	// The rounding error stays below 2^(RECIP_SHIFT-31), so the quotient
	// is exact for every magnitude below 2^31.
	localparam int RECIP_SHIFT = 47;
	localparam logic [31:0] RECIP =
		32'(((64'd1 << RECIP_SHIFT) + 64'(OUT_RATE) - 64'd1) / 64'(OUT_RATE));

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEXT,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_STORE,
		ST_EMIT
	} lirs_state_t;

endpackage

### hdl/linear_interp_resampler_to_44100.sv
// Linear interpolation sample rate converter to 44100 Hz, top level.
// Each result word is made in steps: decide, then for each of the two channels multiply,
// add, reciprocal multiply and store on one shared 32x32 multiplier, then emit.
// The block is not ready for a new source word while it works on the results of the
// last one, nor while it waits on the sink to take a result word.
// Reset (arst_n low) clears the stream state and loads the default registers.
// Depends on lirs_pkg.
module linear_interp_resampler_to_44100
	import lirs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [17:0] wr_data,
	// Source frames.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] left_in, [31:16] right_in
	input  logic        s_tlast,   // is_last
	// Output frames at 44100 Hz.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] left_out, [31:16] right_out
	output logic        m_tlast    // last_of_run
);

	lirs_state_t state_q, state_d;

	// Configuration.
	logic [17:0] rate_q;
	logic [1:0]  chan_q;

	// Stream state.
	logic signed [15:0] prev_l_q, prev_r_q;
	logic signed [15:0] cur_l_q, cur_r_q;
	logic               have_prev_q;
	logic               done_q;
	logic [17:0]        phase_q;
	logic [17:0]        step_q;
	logic               last_q;
	logic [2:0]         cnt_q;
	logic               fin_q;
	logic               ch_q;

	// Datapath.
	logic [63:0]        prod_q;
	logic               dneg_q;
	logic [30:0]        mag_q;
	logic               sign_q;
	logic signed [15:0] res_l_q, res_r_q;

	// Output register.
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        out_last_q;

	// Sequencer outputs.
	logic [31:0] mul_a, mul_b;
	logic        emit_go;

	// Clamped rate and incoming samples.
	logic [17:0]        step_in;
	logic signed [15:0] in_l, in_r;

	// Operands of the current channel.
	logic signed [15:0] op_prev, op_cur, op_b;
	logic signed [16:0] diff;
	logic [15:0]        diff_mag;
	logic [15:0]        ph_eff;
	logic signed [32:0] base, num;
	logic [32:0]        num_mag;
	logic [15:0]        quo;
	logic signed [15:0] res;

	// Decisions on the phase.
	logic [17:0] phase_adv;
	logic        seg_more;
	logic        seg_open;

	assign step_in = (rate_q < RATE_MIN) ? RATE_MIN :
		(rate_q > RATE_MAX) ? RATE_MAX : rate_q;
	assign in_l = signed'(s_tdata[15:0]);
	assign in_r = (chan_q == CHAN_MONO) ? in_l : signed'(s_tdata[31:16]);

	// Blend (prev, cur) at the phase, or (prev, 0) for the closing output.
	assign op_prev  = ch_q ? prev_r_q : prev_l_q;
	assign op_cur   = ch_q ? cur_r_q : cur_l_q;
	assign op_b     = fin_q ? 16'sd0 : op_cur;
	assign diff     = 17'(op_b) - 17'(op_prev);
	assign diff_mag = diff[16] ? 16'(-diff) : diff[15:0];
	assign ph_eff   = (phase_q >= OUT_RATE) ? OUT_RATE[15:0] : phase_q[15:0];

	// prev*OUT_RATE + (cur-prev)*phase, then its magnitude and sign.
	assign base    = 33'(op_prev) * 33'(signed'({1'b0, OUT_RATE}));
	assign num     = dneg_q ? base - signed'({1'b0, prod_q[31:0]})
	                        : base + signed'({1'b0, prod_q[31:0]});
	assign num_mag = num[32] ? 33'(-num) : 33'(num);

	// Quotient by OUT_RATE from the reciprocal product, truncated to zero.
	assign quo = prod_q[RECIP_SHIFT +: 16];
	assign res = sign_q ? signed'(16'(-quo)) : signed'(quo);

	assign phase_adv = phase_q + step_q;
	assign seg_more  = (phase_adv < OUT_RATE) && ((cnt_q + 3'd1) < SEG_CAP);
	assign seg_open  = (phase_q < OUT_RATE) && (cnt_q < SEG_CAP);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && !done_q) begin
					if (have_prev_q) begin
						state_d = ST_NEXT;
					end else if (s_tlast) begin
						state_d = ST_MUL;
					end
				end
			end
			ST_NEXT: begin
				if (seg_open || last_q) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MUL:   state_d = ST_SUM;
			ST_SUM:   state_d = ST_DIV;
			ST_DIV:   state_d = ST_STORE;
			ST_STORE: state_d = ch_q ? ST_EMIT : ST_MUL;
			ST_EMIT: begin
				if (emit_go) begin
					state_d = fin_q ? ST_IDLE : ST_NEXT;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and shared multiplier operands.
	always_comb begin
		s_tready = 1'b0;
		mul_a    = 32'd0;
		mul_b    = 32'd0;
		emit_go  = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_MUL: begin
				mul_a = 32'(diff_mag);
				mul_b = 32'(ph_eff);
			end
			ST_DIV: begin
				mul_a = {1'b0, mag_q};
				mul_b = RECIP;
			end
			ST_EMIT: emit_go = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
			chan_q <= CHAN_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_SOURCE_RATE:   rate_q <= wr_data;
				REG_CHANNEL_COUNT: chan_q <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	// Stream and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			have_prev_q <= 1'b0;
			done_q      <= 1'b0;
			phase_q     <= '0;
			step_q      <= '0;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			fin_q       <= 1'b0;
			ch_q        <= 1'b0;
		end else begin
			case (state_q)
				// Take a word; the first word is only stored, unless it also ends the stream.
				ST_IDLE: begin
					if (s_tvalid && !done_q) begin
						step_q <= step_in;
						last_q <= s_tlast;
						cnt_q  <= '0;
						ch_q   <= 1'b0;
						if (!have_prev_q) begin
							prev_l_q    <= in_l;
							prev_r_q    <= in_r;
							have_prev_q <= 1'b1;
							phase_q     <= '0;
							fin_q       <= s_tlast;
						end
					end
				end
				// Start another output in the segment, or close it.
				ST_NEXT: begin
					ch_q <= 1'b0;
					if (!seg_open) begin
						phase_q  <= (phase_q >= OUT_RATE) ? phase_q - OUT_RATE : '0;
						prev_l_q <= cur_l_q;
						prev_r_q <= cur_r_q;
						fin_q    <= last_q;
					end else if (cnt_q == SEG_CAP) begin
						fin_q <= 1'b0;
					end
				end
				ST_STORE: ch_q <= !ch_q;
				// Hand the word over and advance the phase, or after the closing word mark the stream done.
				ST_EMIT: begin
					if (emit_go) begin
						if (fin_q) begin
							done_q <= 1'b1;
							fin_q  <= 1'b0;
						end else begin
							phase_q <= phase_adv;
							cnt_q   <= cnt_q + 3'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Current frame samples.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cur_l_q <= in_l;
			cur_r_q <= in_r;
		end
	end

	// Shared multiplier and the arithmetic around it.
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL || state_q == ST_DIV) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == ST_MUL) begin
			dneg_q <= diff[16];
		end
		if (state_q == ST_SUM) begin
			mag_q  <= num_mag[30:0];
			sign_q <= num[32];
		end
		if (state_q == ST_STORE) begin
			if (ch_q) begin
				res_r_q <= res;
			end else begin
				res_l_q <= res;
			end
		end
	end

	// Output register: holds a finished word while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_data_q <= {res_r_q, res_l_q};
			out_last_q <= fin_q || (!seg_more && !last_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule
